/* rtl/pmr_pkg.sv */
package pmr_pkg;

  localparam int DATA_W     = 32;
  localparam int CUM_W      = 40;
  localparam int POSE_W     = 3 * DATA_W;
  localparam int COUNT_W    = 9;
  localparam int IDX_OUT_W  = 8;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 5 * DATA_W;
  localparam int OUT_DATA_W = IDX_OUT_W + POSE_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd200;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [STATUS_W-1:0] ST_LOADED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DRAWN      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABOVE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOAD_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK0,
    S_CHKT,
    S_PROBE,
    S_POSE,
    S_EMIT
  } state_t;

endpackage

/* rtl/pmr_store.sv */
module pmr_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [pmr_pkg::CUM_W-1:0] wcum,
  input  logic [pmr_pkg::POSE_W-1:0] wpose,
  input  logic                      cum_re,
  input  logic [AW-1:0]             cum_raddr,
  output logic [pmr_pkg::CUM_W-1:0] cum_rdata,
  input  logic                      pose_re,
  input  logic [AW-1:0]             pose_raddr,
  output logic [pmr_pkg::POSE_W-1:0] pose_rdata
);
  import pmr_pkg::*;

  logic [CUM_W-1:0]  cum_mem  [DEPTH];
  logic [POSE_W-1:0] pose_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cum_mem[waddr]  <= wcum;
      pose_mem[waddr] <= wpose;
    end
  end

  always_ff @(posedge clk) begin
    if (cum_re) begin
      cum_rdata <= cum_mem[cum_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pose_re) begin
      pose_rdata <= pose_mem[pose_raddr];
    end
  end

endmodule

/* rtl/particle_multinomial_resampler.sv */
// Multinomial resampler for a particle filter. Load items (tuser = 0) append one particle:
// its weight is added to a 40-bit running sum that is stored with the pose in the next slot,
// and the result echoes the slot and pose. Draw items (tuser = 1) bring a 32-bit uniform
// fraction; the block binary-searches the cumulative table and returns the chosen index and
// its pose. Set size comes from cfg_wdata (0 acts as 1, values above MAX_PARTICLES clip).
// A load result goes through the emit step into the output register, and the block then
// returns to idle for the next item. A draw reads the first cumulative entry and, unless the
// fraction is below it, the last one, then runs k <= ceil(log2(n)) search probes, then reads
// the pose. Every search step is one read of the cumulative table; the pose comes from a
// separate pose memory with its own read port.
// One item is in work at a time; the next item is accepted while a finished result still
// waits on the output register, and a result that cannot leave holds the block in its
// emit step.
module particle_multinomial_resampler #(
  parameter int MAX_PARTICLES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // weight, pos_x, pos_y, heading, random_value (32 bits each, lowest first)
  input  logic [pmr_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // chosen_index (8), out_x, out_y, out_heading (32 bits each, lowest first)
  output logic [pmr_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status
  output logic [pmr_pkg::STATUS_W-1:0]      out_tuser,
  input  logic                              cfg_we,
  input  logic [pmr_pkg::COUNT_W-1:0]       cfg_wdata
);
  import pmr_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int POS_W = IDX_W + 1;

  state_t state_r, state_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [IDX_OUT_W-1:0]  res_idx_r, res_idx_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [POSE_W-1:0]     res_pose_r, res_pose_nxt;
  logic [DATA_W-1:0]     rnd_r, rnd_nxt;
  logic [IDX_W-1:0]      top_r, top_nxt;
  logic [IDX_W-1:0]      bot_r, bot_nxt;
  logic [CUM_W-1:0]      running_sum_r, running_sum_nxt;
  logic [POS_W-1:0]      load_pos_r, load_pos_nxt;
  logic                  draw_phase_r, draw_phase_nxt;
  logic [COUNT_W-1:0]    count_r;

  logic [POS_W-1:0]  n_act;
  logic [IDX_W-1:0]  n_m1;
  logic [POS_W-1:0]  lp_eff;
  logic [CUM_W-1:0]  rnd40;
  logic [CUM_W-1:0]  sum_base;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid;
  logic [IDX_W-1:0]  nt, nb;
  logic [IDX_W:0]    nmid_sum;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [CUM_W-1:0]  mem_wcum;
  logic              cum_re;
  logic [IDX_W-1:0]  cum_raddr;
  logic [CUM_W-1:0]  cum_rdata;
  logic              pose_re;
  logic [IDX_W-1:0]  pose_raddr;
  logic [POSE_W-1:0] pose_rdata;

  // Writes happen only on a load accept in idle, reads only while a draw is in work,
  // so the same entry is never written and read in one cycle.
  pmr_store #(
    .DEPTH(MAX_PARTICLES),
    .AW   (IDX_W)
  ) u_store (
    .clk       (clk),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wcum      (mem_wcum),
    .wpose     (in_tdata[4*DATA_W-1:DATA_W]),
    .cum_re    (cum_re),
    .cum_raddr (cum_raddr),
    .cum_rdata (cum_rdata),
    .pose_re   (pose_re),
    .pose_raddr(pose_raddr),
    .pose_rdata(pose_rdata)
  );

  always_comb begin
    if (count_r == '0) begin
      n_act = POS_W'(1);
    end else if ({23'd0, count_r} > 32'(MAX_PARTICLES)) begin
      n_act = POS_W'(MAX_PARTICLES);
    end else begin
      n_act = POS_W'(count_r);
    end
  end

  assign n_m1     = IDX_W'(n_act - POS_W'(1));
  assign lp_eff   = draw_phase_r ? '0 : load_pos_r;
  assign rnd40    = {8'd0, rnd_r};
  assign sum_base = (lp_eff == '0) ? '0 : running_sum_r;
  assign mid_sum  = {1'b0, top_r} + {1'b0, bot_r};
  assign mid      = mid_sum[IDX_W:1];
  assign nt       = (cum_rdata < rnd40) ? top_r : mid;
  assign nb       = (cum_rdata < rnd40) ? mid : bot_r;
  assign nmid_sum = {1'b0, nt} + {1'b0, nb};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    out_status_nxt  = out_status_r;
    res_idx_nxt     = res_idx_r;
    res_status_nxt  = res_status_r;
    res_pose_nxt    = res_pose_r;
    rnd_nxt         = rnd_r;
    top_nxt         = top_r;
    bot_nxt         = bot_r;
    running_sum_nxt = running_sum_r;
    load_pos_nxt    = load_pos_r;
    draw_phase_nxt  = draw_phase_r;
    mem_we          = 1'b0;
    mem_waddr       = lp_eff[IDX_W-1:0];
    mem_wcum        = sum_base + {8'd0, in_tdata[DATA_W-1:0]};
    cum_re          = 1'b0;
    cum_raddr       = '0;
    pose_re         = 1'b0;
    pose_raddr      = top_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EMIT;
          if (in_tuser == CMD_LOAD) begin
            draw_phase_nxt = 1'b0;
            if (lp_eff >= n_act) begin
              load_pos_nxt   = lp_eff;
              res_idx_nxt    = '0;
              res_pose_nxt   = '0;
              res_status_nxt = ST_LOAD_FULL;
            end else begin
              mem_we          = 1'b1;
              running_sum_nxt = mem_wcum;
              load_pos_nxt    = POS_W'(lp_eff + POS_W'(1));
              res_idx_nxt     = IDX_OUT_W'(lp_eff);
              res_pose_nxt    = in_tdata[4*DATA_W-1:DATA_W];
              res_status_nxt  = ST_LOADED;
            end
          end else begin
            load_pos_nxt = '0;
            if (!draw_phase_r && (load_pos_r < n_act)) begin
              running_sum_nxt = '0;
              res_idx_nxt     = '0;
              res_pose_nxt    = '0;
              res_status_nxt  = ST_INCOMPLETE;
            end else begin
              draw_phase_nxt = 1'b1;
              rnd_nxt        = in_tdata[5*DATA_W-1:4*DATA_W];
              top_nxt        = n_m1;
              bot_nxt        = '0;
              cum_re         = 1'b1;
              cum_raddr      = '0;
              state_nxt      = S_CHK0;
            end
          end
        end
      end

      S_CHK0: begin
        if (rnd40 < cum_rdata) begin
          res_idx_nxt    = '0;
          res_status_nxt = ST_DRAWN;
          pose_re        = 1'b1;
          pose_raddr     = '0;
          state_nxt      = S_POSE;
        end else begin
          cum_re    = 1'b1;
          cum_raddr = top_r;
          state_nxt = S_CHKT;
        end
      end

      S_CHKT: begin
        if (rnd40 > cum_rdata) begin
          res_idx_nxt    = IDX_OUT_W'(top_r);
          res_status_nxt = ST_ABOVE;
          pose_re        = 1'b1;
          pose_raddr     = top_r;
          state_nxt      = S_POSE;
        end else if ((top_r - bot_r) > IDX_W'(1)) begin
          cum_re    = 1'b1;
          cum_raddr = mid;
          state_nxt = S_PROBE;
        end else begin
          res_idx_nxt    = IDX_OUT_W'(top_r);
          res_status_nxt = ST_DRAWN;
          pose_re        = 1'b1;
          pose_raddr     = top_r;
          state_nxt      = S_POSE;
        end
      end

      // cum_rdata holds the entry at the current midpoint
      S_PROBE: begin
        top_nxt = nt;
        bot_nxt = nb;
        if ((nt - nb) > IDX_W'(1)) begin
          cum_re    = 1'b1;
          cum_raddr = nmid_sum[IDX_W:1];
        end else begin
          res_idx_nxt    = IDX_OUT_W'(nt);
          res_status_nxt = ST_DRAWN;
          pose_re        = 1'b1;
          pose_raddr     = nt;
          state_nxt      = S_POSE;
        end
      end

      S_POSE: begin
        res_pose_nxt = pose_rdata;
        state_nxt    = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = {res_pose_r, res_idx_r};
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      running_sum_r <= '0;
      load_pos_r    <= '0;
      draw_phase_r  <= 1'b0;
      count_r       <= COUNT_RESET;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      running_sum_r <= running_sum_nxt;
      load_pos_r    <= load_pos_nxt;
      draw_phase_r  <= draw_phase_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_status_r <= res_status_nxt;
    res_pose_r   <= res_pose_nxt;
    rnd_r        <= rnd_nxt;
    top_r        <= top_nxt;
    bot_r        <= bot_nxt;
  end

  a_draw_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_DRAW)) |=> (load_pos_r == '0))
    else $error("load position not cleared by draw");

  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> ((top_r - bot_r) > IDX_W'(1)))
    else $error("search probe with collapsed window");

  a_search_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CHK0) || (state_r == S_CHKT) || (state_r == S_PROBE)) |-> draw_phase_r)
    else $error("search running outside drawing phase");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r <= ST_INCOMPLETE))
    else $error("bad result status");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && !out_valid_r) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result not moved to output register");

endmodule

/* test/particle_multinomial_resampler_tb.sv */
module particle_multinomial_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmr_pkg::*;

  localparam int MAX_P = 256;

  typedef struct packed {
    logic                cmd;
    logic [DATA_W-1:0]   weight;
    logic [DATA_W-1:0]   pos_x;
    logic [DATA_W-1:0]   pos_y;
    logic [DATA_W-1:0]   heading;
    logic [DATA_W-1:0]   rand_frac;
  } particle_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic [DATA_W-1:0]    x;
    logic [DATA_W-1:0]    y;
    logic [DATA_W-1:0]    heading;
    logic [STATUS_W-1:0]  status;
  } pick_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_we;
  logic [COUNT_W-1:0]    cfg_wdata;

  particle_multinomial_resampler #(
    .MAX_PARTICLES(MAX_P)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block's tables and registers
  logic [CUM_W-1:0]   cum_tbl [MAX_P];
  logic [DATA_W-1:0]  px_tbl  [MAX_P];
  logic [DATA_W-1:0]  py_tbl  [MAX_P];
  logic [DATA_W-1:0]  hd_tbl  [MAX_P];
  logic [CUM_W-1:0]   run_sum;
  int                 load_pos;
  bit                 drawing;
  logic [COUNT_W-1:0] particle_count;

  pick_t expected_picks[$];
  int    mismatch_count;
  int    items_sent;
  bit    sender_idle;
  bit    receiver_idle;
  int    hold_off_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int active_count();
    if (particle_count == 0) return 1;
    if (particle_count > MAX_P) return MAX_P;
    return int'(particle_count);
  endfunction

  task automatic predict_resample(input particle_item_t it);
    pick_t p;
    int n, slot, bottom, top, mid;
    logic [CUM_W-1:0] r;
    n = active_count();
    p = '0;
    if (it.cmd == CMD_LOAD) begin
      if (drawing) begin
        drawing = 1'b0;
        load_pos = 0;
      end
      if (load_pos >= n) begin
        p.status = ST_LOAD_FULL;
      end else begin
        slot = load_pos;
        if (slot == 0) run_sum = '0;
        run_sum = run_sum + {8'd0, it.weight};
        cum_tbl[slot] = run_sum;
        px_tbl[slot] = it.pos_x;
        py_tbl[slot] = it.pos_y;
        hd_tbl[slot] = it.heading;
        load_pos = slot + 1;
        p.index = slot[IDX_OUT_W-1:0];
        p.x = it.pos_x;
        p.y = it.pos_y;
        p.heading = it.heading;
        p.status = ST_LOADED;
      end
    end else if (!drawing && load_pos < n) begin
      load_pos = 0;
      run_sum = '0;
      p.status = ST_INCOMPLETE;
    end else begin
      drawing = 1'b1;
      load_pos = 0;
      r = {8'd0, it.rand_frac};
      bottom = 0;
      top = n - 1;
      p.status = ST_DRAWN;
      if (r < cum_tbl[0]) begin
        top = 0;
      end else if (r > cum_tbl[top]) begin
        p.status = ST_ABOVE;
      end else begin
        while (top - bottom > 1) begin
          mid = (top + bottom) / 2;
          if (cum_tbl[mid] < r) bottom = mid;
          else top = mid;
        end
      end
      p.index = top[IDX_OUT_W-1:0];
      p.x = px_tbl[top];
      p.y = py_tbl[top];
      p.heading = hd_tbl[top];
    end
    expected_picks.push_back(p);
  endtask

  // entered and left at a falling edge
  task automatic send_item(input particle_item_t it);
    int gap;
    gap = sender_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {it.rand_frac, it.heading, it.pos_y, it.pos_x, it.weight};
    predict_resample(it);
    items_sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_particle(input logic [31:0] w, x, y, h);
    particle_item_t it;
    it.cmd = CMD_LOAD;
    it.weight = w;
    it.pos_x = x;
    it.pos_y = y;
    it.heading = h;
    it.rand_frac = $urandom;
    send_item(it);
  endtask

  task automatic draw_sample(input logic [31:0] r);
    particle_item_t it;
    it.cmd = CMD_DRAW;
    it.weight = $urandom;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.heading = $urandom;
    it.rand_frac = r;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_picks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_particle_count(input int v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[COUNT_W-1:0];
    particle_count = v[COUNT_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_weight(input int mode);
    case (mode)
      0:       return $urandom;
      1:       return $urandom >> $urandom_range(6, 28);
      default: return ($urandom_range(0, 1) == 1) ? 32'd0 : ($urandom >> 4);
    endcase
  endfunction

  // aim at the edges of the cumulative table: below, exact hits, neighbors, above
  function automatic logic [31:0] pick_draw_value();
    int k;
    logic [CUM_W-1:0] c;
    k = $urandom_range(0, active_count() - 1);
    c = cum_tbl[k];
    case ($urandom_range(0, 6))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return (c[39:32] != 0) ? $urandom : c[31:0];
      3:       return (c[39:32] != 0) ? $urandom : c[31:0] + 32'd1;
      4:       return (c[39:32] != 0) ? $urandom : c[31:0] - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic check_pick(input pick_t got);
    pick_t exp_p;
    if (expected_picks.size() == 0) begin
      $error("result item with nothing expected: index %0d status %0d",
             got.index, got.status);
      mismatch_count++;
      return;
    end
    exp_p = expected_picks.pop_front();
    if (got.index !== exp_p.index) begin
      $error("chosen_index: expected %0d, actual %0d", exp_p.index, got.index);
      mismatch_count++;
    end
    if (got.x !== exp_p.x) begin
      $error("out_x: expected %h, actual %h", exp_p.x, got.x);
      mismatch_count++;
    end
    if (got.y !== exp_p.y) begin
      $error("out_y: expected %h, actual %h", exp_p.y, got.y);
      mismatch_count++;
    end
    if (got.heading !== exp_p.heading) begin
      $error("out_heading: expected %h, actual %h", exp_p.heading, got.heading);
      mismatch_count++;
    end
    if (got.status !== exp_p.status) begin
      $error("status: expected %0d, actual %0d", exp_p.status, got.status);
      mismatch_count++;
    end
  endtask

  initial begin : result_sink
    int stall;
    pick_t got;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = receiver_idle ? $urandom_range(0, 10) : 0;
      if (hold_off_req > 0) begin
        stall = hold_off_req;
        hold_off_req = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.index   = out_tdata[7:0];
      got.x       = out_tdata[39:8];
      got.y       = out_tdata[71:40];
      got.heading = out_tdata[103:72];
      got.status  = out_tuser;
      check_pick(got);
      @(negedge clk);
    end
  end

  // default count of 200 after reset: nothing loaded, draws are incomplete
  task automatic test_reset_state();
    draw_sample(32'h1234_5678);
    load_particle(32'h0100_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0003_243F);
    draw_sample(32'd0);
  endtask

  // zero weight in the middle makes an exact-hit tie
  task automatic test_small_set();
    write_particle_count(4);
    load_particle(32'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    load_particle(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
    load_particle(32'h2000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    load_particle(32'h1000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    load_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    draw_sample(32'h0000_0000);
    draw_sample(32'h4000_0000);
    draw_sample(32'h5FFF_FFFF);
    draw_sample(32'h7000_0000);
    draw_sample(32'h7000_0001);
    draw_sample(32'hFFFF_FFFF);
    load_particle(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
    draw_sample(32'h0000_0001);
  endtask

  // count 0 behaves as 1; full-scale weights push the sum past 32 bits
  task automatic test_count_limits();
    write_particle_count(0);
    load_particle(32'hFFFF_FFFF, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
    load_particle(32'h0000_0001, 32'h4444_4444, 32'h5555_5555, 32'h6666_6666);
    draw_sample(32'hFFFF_FFFF);
    draw_sample(32'h0000_0000);
    write_particle_count(2);
    load_particle(32'hFFFF_FFFF, 32'h7777_7777, 32'h8888_8888, 32'h9999_9999);
    load_particle(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'hBBBB_BBBB, 32'hCCCC_CCCC);
    draw_sample(32'hFFFF_FFFF);
    draw_sample(32'h0000_0000);
  endtask

  // counts above the table size clip to it
  task automatic test_full_table();
    write_particle_count(511);
    for (int i = 0; i < MAX_P; i++) begin
      load_particle(($urandom_range(0, 7) == 0) ? 32'd0 : ($urandom >> 9),
                    $urandom, $urandom, $urandom);
    end
    repeat (2) load_particle($urandom, $urandom, $urandom, $urandom);
    repeat (6) draw_sample(pick_draw_value());
    // same effective size, so the set stays valid for further draws
    write_particle_count(MAX_P);
    repeat (4) draw_sample(pick_draw_value());
  endtask

  task automatic test_backpressure();
    write_particle_count(8);
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    hold_off_req = 300;
    for (int i = 0; i < 8; i++) load_particle(pick_weight(1), $urandom, $urandom, $urandom);
    repeat (8) draw_sample(pick_draw_value());
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
  endtask

  task automatic test_random_sets(input int budget);
    int stop_at, n, mode, extra;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 7))
        0:       write_particle_count(0);
        1:       write_particle_count(1);
        2:       write_particle_count(2);
        3:       write_particle_count($urandom_range(17, 40));
        default: write_particle_count($urandom_range(3, 12));
      endcase
      sender_idle = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      n = active_count();
      repeat ($urandom_range(1, 3)) begin
        mode = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
          // occasional early draw breaks the set
          if (i > 0 && $urandom_range(0, 39) == 0) draw_sample($urandom);
          load_particle(pick_weight(mode), $urandom, $urandom, $urandom);
        end
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (extra) load_particle($urandom, $urandom, $urandom, $urandom);
        repeat ($urandom_range(1, 8)) draw_sample(pick_draw_value());
      end
    end
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
  endtask

  initial begin : stimulus
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_LOAD;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    for (int i = 0; i < MAX_P; i++) begin
      cum_tbl[i] = '0;
      px_tbl[i] = '0;
      py_tbl[i] = '0;
      hd_tbl[i] = '0;
    end
    run_sum = '0;
    load_pos = 0;
    drawing = 1'b0;
    particle_count = COUNT_RESET;
    mismatch_count = 0;
    items_sent = 0;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    hold_off_req = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_small_set();
    test_count_limits();
    test_full_table();
    test_backpressure();
    test_random_sets(330);

    wait_idle();
    repeat (30) @(negedge clk);
    if (mismatch_count == 0 && expected_picks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* particle_multinomial_resampler.f */
rtl/pmr_pkg.sv
rtl/pmr_store.sv
rtl/particle_multinomial_resampler.sv
test/particle_multinomial_resampler_tb.sv
